[rtl/core/gcd_pkg.sv]
package gcd_pkg;

    // number formats
    localparam int FRACTION_BITS = 16;
    localparam int CORDIC_STAGES = 24;
    localparam int FIELD_W       = 27;              // input coordinate width
    localparam int LON_W         = 26;              // output longitude width
    localparam int LAT_W         = 24;              // output latitude width
    localparam int XW            = 36;              // cordic vector width, Q30
    localparam int ZW            = 48;              // angle width, Q40 radians
    localparam int QF            = 30;              // vector fraction bits
    localparam int IDX_W         = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

    // fixed constants
    localparam logic [63:0] PI_Q61     = 64'h6487ED5110B4611A;
    localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A94;
    localparam logic signed [ZW-1:0] PI_Q40 =
        ZW'((PI_Q61 + (64'd1 << 20)) >> 21);
    localparam logic signed [ZW-1:0] HALF_PI_Q40 =
        ZW'((PI_Q61 + (64'd1 << 21)) >> 22);
    localparam logic [63:0] D2R_Q61 = (PI_Q61 + 64'd90) / 64'd180;
    localparam logic [63:0] R2D_Q30 =
        (((INV_PI_Q64 >> 8) * 64'd180) + (64'd1 << 25)) >> 26;
    localparam logic signed [XW-1:0] GAIN_Q30 = XW'(64'h26DD3B6A);
    localparam logic signed [XW-1:0] FAC_Q30 =
        XW'(((64'd9932773 << 30) + 64'd5000000) / 64'd10000000);

    // degree to radian multiply split
    localparam int D2R_W  = 56;
    localparam int D2R_H  = D2R_W / 2;
    localparam int DSUM_W = FIELD_W + D2R_W + 1;
    localparam int SH_D   = 21 + FRACTION_BITS;

    // radian to degree multiply split
    localparam int R2D_W  = 36;
    localparam int RH     = ZW / 2;
    localparam int RSUM_W = ZW + R2D_W + 1;
    localparam int SH_R   = 70 - FRACTION_BITS;

    // degree limits on the input grid
    localparam logic signed [FIELD_W-1:0] DEG90  = FIELD_W'(64'd90 << FRACTION_BITS);
    localparam logic signed [FIELD_W-1:0] DEG180 = FIELD_W'(64'd180 << FRACTION_BITS);
    localparam logic signed [FIELD_W-1:0] DEG360 = FIELD_W'(64'd360 << FRACTION_BITS);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LAT  = 3'd1,
        ST_BAD_LON  = 3'd2,
        ST_BAD_DIST = 3'd3,
        ST_BAD_AZ   = 3'd4
    } status_t;

    // data that rides alongside the cordic chains
    typedef struct packed {
        status_t                     status;
        logic signed [FIELD_W-1:0]   lon;
        logic signed [FIELD_W-1:0]   lat;
        logic signed [ZW-1:0]        latr;
        logic signed [ZW-1:0]        distr;
        logic signed [ZW-1:0]        azr;
        logic signed [ZW-1:0]        dlon;
        logic signed [XW-1:0]        c2;
    } side_t;

    typedef logic signed [ZW-1:0] atan_tab_t [CORDIC_STAGES];

    // unsigned quotient by shift and subtract, for table building only
    function automatic longint unsigned div_u64(input longint unsigned n,
                                                input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q40 from the arctangent series
    function automatic atan_tab_t build_atan_tab();
        atan_tab_t          tab;
        longint             acc;
        longint unsigned    t;
        int                 e;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (i == 0) begin
                tab[i] = ZW'((PI_Q61 + (64'd1 << 22)) >> 23);
            end else begin
                acc = 0;
                for (int k = 0; k < 32; k++) begin
                    e = i * (2 * k + 1);
                    if (e <= 62) begin
                        t = div_u64(64'd1 << (62 - e), 64'(2 * k + 1));
                        if (k[0])
                            acc = acc - longint'(t);
                        else
                            acc = acc + longint'(t);
                    end
                end
                tab[i] = ZW'((acc + (64'sd1 <<< 21)) >>> 22);
            end
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan_tab();

    // Q30 product, rounded to nearest with ties away from zero
    function automatic logic signed [XW-1:0] mulq30(input logic signed [XW-1:0] a,
                                                   input logic signed [XW-1:0] b);
        logic               neg;
        logic [XW-1:0]      ua;
        logic [XW-1:0]      ub;
        logic [2*XW-1:0]    p;
        neg = a[XW-1] ^ b[XW-1];
        ua  = a[XW-1] ? XW'(-a) : XW'(a);
        ub  = b[XW-1] ? XW'(-b) : XW'(b);
        p   = (2*XW)'(ua) * (2*XW)'(ub);
        p   = (p + ((2*XW)'(1) << (QF - 1))) >> QF;
        return neg ? -XW'(p) : XW'(p);
    endfunction

endpackage

[rtl/core/gcd_cordic_cell.sv]
module gcd_cordic_cell
    import gcd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic                    vect,
    input  logic [IDX_W-1:0]        idx,
    input  logic signed [XW-1:0]    x_in,
    input  logic signed [XW-1:0]    y_in,
    input  logic signed [ZW-1:0]    z_in,
    output logic signed [XW-1:0]    x_out,
    output logic signed [XW-1:0]    y_out,
    output logic signed [ZW-1:0]    z_out
);

    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic                 pos;

    // one micro-rotation, direction from the angle or from the sign of y
    always_comb begin
        xs  = x_in >>> idx;
        ys  = y_in >>> idx;
        pos = vect ? y_in[XW-1] : ~z_in[ZW-1];
        if (pos) begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN_TAB[idx];
        end else begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN_TAB[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

[rtl/core/gcd_cordic_chain.sv]
module gcd_cordic_chain
    import gcd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    vect,
    input  logic                    in_valid,
    input  side_t                   in_side,
    input  logic signed [XW-1:0]    in_x,
    input  logic signed [XW-1:0]    in_y,
    input  logic signed [ZW-1:0]    in_z,
    output logic                    out_valid,
    output side_t                   out_side,
    output logic signed [XW-1:0]    out_x,
    output logic signed [XW-1:0]    out_y,
    output logic signed [ZW-1:0]    out_z
);

    logic signed [XW-1:0] xs [0:CORDIC_STAGES];
    logic signed [XW-1:0] ys [0:CORDIC_STAGES];
    logic signed [ZW-1:0] zs [0:CORDIC_STAGES];

    logic                 valid_reg [0:CORDIC_STAGES];
    logic                 flip_reg  [0:CORDIC_STAGES];
    logic                 zero_reg  [0:CORDIC_STAGES];
    side_t                side_reg  [0:CORDIC_STAGES];

    logic signed [XW-1:0] pre_x_reg, pre_x_next;
    logic signed [XW-1:0] pre_y_reg, pre_y_next;
    logic signed [ZW-1:0] pre_z_reg, pre_z_next;
    logic                 pre_flip;
    logic                 pre_zero;

    logic                 post_valid_reg;
    side_t                post_side_reg;
    logic signed [XW-1:0] post_x_reg, post_x_next;
    logic signed [XW-1:0] post_y_reg, post_y_next;
    logic signed [ZW-1:0] post_z_reg, post_z_next;

    // quadrant folding ahead of the iterations
    always_comb begin
        pre_flip   = 1'b0;
        pre_zero   = 1'b0;
        pre_x_next = GAIN_Q30;
        pre_y_next = '0;
        pre_z_next = in_z;
        if (vect) begin
            pre_zero   = (in_x == '0) && (in_y == '0);
            pre_x_next = in_x;
            pre_y_next = in_y;
            pre_z_next = '0;
            if (in_x[XW-1]) begin
                pre_flip   = 1'b1;
                pre_x_next = -in_x;
                pre_y_next = -in_y;
                pre_z_next = in_y[XW-1] ? -PI_Q40 : PI_Q40;
            end
        end else if (in_z > HALF_PI_Q40) begin
            pre_flip   = 1'b1;
            pre_z_next = in_z - PI_Q40;
        end else if (in_z < -HALF_PI_Q40) begin
            pre_flip   = 1'b1;
            pre_z_next = in_z + PI_Q40;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_x_reg   <= pre_x_next;
            pre_y_reg   <= pre_y_next;
            pre_z_reg   <= pre_z_next;
            flip_reg[0] <= pre_flip;
            zero_reg[0] <= pre_zero;
            side_reg[0] <= in_side;
        end
    end

    assign xs[0] = pre_x_reg;
    assign ys[0] = pre_y_reg;
    assign zs[0] = pre_z_reg;

    // row of iteration cells
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        gcd_cordic_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .vect  (vect),
            .idx   (IDX_W'(i)),
            .x_in  (xs[i]),
            .y_in  (ys[i]),
            .z_in  (zs[i]),
            .x_out (xs[i+1]),
            .y_out (ys[i+1]),
            .z_out (zs[i+1])
        );
    end

    // flags and side data travel beside the cells
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 1; i <= CORDIC_STAGES; i++) begin
                flip_reg[i] <= flip_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= CORDIC_STAGES; i++)
                valid_reg[i] <= 1'b0;
            post_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= CORDIC_STAGES; i++)
                valid_reg[i] <= valid_reg[i-1];
            post_valid_reg <= valid_reg[CORDIC_STAGES];
        end
    end

    // undo the folding, zero vector gives zero
    always_comb begin
        post_x_next = xs[CORDIC_STAGES];
        post_y_next = ys[CORDIC_STAGES];
        post_z_next = zs[CORDIC_STAGES];
        if (vect) begin
            if (zero_reg[CORDIC_STAGES]) begin
                post_x_next = '0;
                post_y_next = '0;
                post_z_next = '0;
            end
        end else if (flip_reg[CORDIC_STAGES]) begin
            post_x_next = -xs[CORDIC_STAGES];
            post_y_next = -ys[CORDIC_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            post_x_reg    <= post_x_next;
            post_y_reg    <= post_y_next;
            post_z_reg    <= post_z_next;
            post_side_reg <= side_reg[CORDIC_STAGES];
        end
    end

    assign out_valid = post_valid_reg;
    assign out_side  = post_side_reg;
    assign out_x     = post_x_reg;
    assign out_y     = post_y_reg;
    assign out_z     = post_z_reg;

endmodule

[rtl/core/great_circle_destination_point_top.sv]
// Great-circle destination point. Each transaction on the s_ side carries a start
// longitude, start latitude, distance and azimuth in degrees (signed, 16 fraction
// bits); the m_ side returns the end longitude (start plus offset, not wrapped), the
// end latitude and a status code in tuser. Out-of-range inputs give a nonzero status
// and zero coordinates. The datapath is a fixed pipeline of seven CORDIC chains of
// CORDIC_STAGES+2 stages each, five of them in series, plus fourteen arithmetic and
// output stages; one transaction is taken every cycle while the output side keeps up;
// a stalled result parks in a skid register and s_tready drops only once that is full.
// geocentric_mode is sampled by items in flight and must be written while idle.
module great_circle_destination_point_top
    import gcd_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic            cfg_wdata,      // geocentric_mode
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [111:0]    s_tdata,        // lon_start, lat_start, distance, azimuth
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [55:0]     m_tdata,        // lon_end, lat_end
    output logic [2:0]      m_tuser         // status
);

    logic en;
    logic geo_reg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            geo_reg <= 1'b0;
        else if (cfg_we)
            geo_reg <= cfg_wdata;
    end

    // ---------------- input checks ----------------
    logic signed [FIELD_W-1:0] in_lon, in_lat, in_dist, in_az;
    logic signed [FIELD_W-1:0] lon_red, az_red;
    status_t                   in_status;

    assign in_lon  = s_tdata[FIELD_W-1:0];
    assign in_lat  = s_tdata[2*FIELD_W-1:FIELD_W];
    assign in_dist = s_tdata[3*FIELD_W-1:2*FIELD_W];
    assign in_az   = s_tdata[4*FIELD_W-1:3*FIELD_W];

    always_comb begin
        lon_red = (in_lon > DEG180) ? in_lon - DEG360 : in_lon;
        az_red  = (in_az > DEG180) ? in_az - DEG360 : in_az;
        if (in_lat < -DEG90 || in_lat > DEG90)
            in_status = ST_BAD_LAT;
        else if (lon_red < -DEG180 || lon_red > DEG180)
            in_status = ST_BAD_LON;
        else if (in_dist < 0 || in_dist > DEG180)
            in_status = ST_BAD_DIST;
        else if (az_red < -DEG180 || az_red > DEG180)
            in_status = ST_BAD_AZ;
        else
            in_status = ST_OK;
    end

    logic                      s0_valid_reg;
    status_t                   s0_status_reg;
    logic signed [FIELD_W-1:0] s0_lon_reg;
    logic signed [FIELD_W-1:0] s0_d_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_status_reg <= in_status;
            s0_lon_reg    <= lon_red;
            s0_d_reg[0]   <= in_lat;
            s0_d_reg[1]   <= in_dist;
            s0_d_reg[2]   <= az_red;
        end
    end

    // ---------------- degrees to radians ----------------
    logic                      s1_valid_reg;
    status_t                   s1_status_reg;
    logic signed [FIELD_W-1:0] s1_lon_reg, s1_lat_reg;
    logic                      s1_neg_reg [3];
    logic [FIELD_W+D2R_H-1:0]  s1_plo_reg [3];
    logic [FIELD_W+D2R_H-1:0]  s1_phi_reg [3];
    logic [FIELD_W-1:0]        s1_ud      [3];

    always_comb begin
        for (int i = 0; i < 3; i++)
            s1_ud[i] = s0_d_reg[i][FIELD_W-1] ? FIELD_W'(-s0_d_reg[i]) : FIELD_W'(s0_d_reg[i]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_status_reg <= s0_status_reg;
            s1_lon_reg    <= s0_lon_reg;
            s1_lat_reg    <= s0_d_reg[0];
            for (int i = 0; i < 3; i++) begin
                s1_neg_reg[i] <= s0_d_reg[i][FIELD_W-1];
                s1_plo_reg[i] <= (FIELD_W+D2R_H)'(s1_ud[i]) *
                                 (FIELD_W+D2R_H)'(D2R_Q61[D2R_H-1:0]);
                s1_phi_reg[i] <= (FIELD_W+D2R_H)'(s1_ud[i]) *
                                 (FIELD_W+D2R_H)'(D2R_Q61[D2R_W-1:D2R_H]);
            end
        end
    end

    logic                      s2_valid_reg;
    side_t                     s2_side_reg, s2_side_next;
    logic [DSUM_W-1:0]         s2_sum [3];
    logic signed [ZW-1:0]      s2_ang [3];

    // recombine partial products, round and scale
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s2_sum[i] = (DSUM_W'(s1_phi_reg[i]) << D2R_H) + DSUM_W'(s1_plo_reg[i])
                      + (DSUM_W'(1) << (SH_D - 1));
            s2_sum[i] = s2_sum[i] >> SH_D;
            s2_ang[i] = s1_neg_reg[i] ? -ZW'(s2_sum[i]) : ZW'(s2_sum[i]);
        end
        s2_side_next        = '0;
        s2_side_next.status = s1_status_reg;
        s2_side_next.lon    = s1_lon_reg;
        s2_side_next.lat    = s1_lat_reg;
        s2_side_next.latr   = s2_ang[0];
        s2_side_next.distr  = s2_ang[1];
        s2_side_next.azr    = s2_ang[2];
    end

    always_ff @(posedge aclk) begin
        if (en)
            s2_side_reg <= s2_side_next;
    end

    // ---------------- geocentric conversion of the start latitude ----------------
    logic                 g1_valid;
    side_t                g1_side;
    logic signed [XW-1:0] g1_c, g1_s;

    gcd_cordic_chain u_geo_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vect      (1'b0),
        .in_valid  (s2_valid_reg),
        .in_side   (s2_side_reg),
        .in_x      ('0),
        .in_y      ('0),
        .in_z      (s2_side_reg.latr),
        .out_valid (g1_valid),
        .out_side  (g1_side),
        .out_x     (g1_c),
        .out_y     (g1_s),
        .out_z     ()
    );

    logic                 m1_valid_reg;
    side_t                m1_side_reg;
    logic signed [XW-1:0] m1_c_reg, m1_fs_reg;

    // clamp the cosine and scale the sine by the flattening factor
    always_ff @(posedge aclk) begin
        if (en) begin
            m1_side_reg <= g1_side;
            m1_c_reg    <= g1_c[XW-1] ? '0 : g1_c;
            m1_fs_reg   <= mulq30(FAC_Q30, g1_s);
        end
    end

    logic                 g2_valid;
    side_t                g2_side;
    logic signed [ZW-1:0] g2_z;

    gcd_cordic_chain u_geo_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vect      (1'b1),
        .in_valid  (m1_valid_reg),
        .in_side   (m1_side_reg),
        .in_x      (m1_c_reg),
        .in_y      (m1_fs_reg),
        .in_z      ('0),
        .out_valid (g2_valid),
        .out_side  (g2_side),
        .out_x     (),
        .out_y     (),
        .out_z     (g2_z)
    );

    logic                 m2_valid_reg;
    side_t                m2_side_reg;
    logic signed [ZW-1:0] m2_lat1_reg, m2_lat1_next;

    // start latitude in radians, poles pass through exactly
    always_comb begin
        if (!geo_reg)
            m2_lat1_next = g2_side.latr;
        else if (g2_side.lat == DEG90)
            m2_lat1_next = HALF_PI_Q40;
        else if (g2_side.lat == -DEG90)
            m2_lat1_next = -HALF_PI_Q40;
        else
            m2_lat1_next = g2_z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_side_reg <= g2_side;
            m2_lat1_reg <= m2_lat1_next;
        end
    end

    // ---------------- sines and cosines of the three angles ----------------
    logic                 r_valid;
    side_t                r_side;
    logic signed [XW-1:0] c1, s1, cc, sc, ca, sa;

    gcd_cordic_chain u_rot_lat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vect      (1'b0),
        .in_valid  (m2_valid_reg),
        .in_side   (m2_side_reg),
        .in_x      ('0),
        .in_y      ('0),
        .in_z      (m2_lat1_reg),
        .out_valid (r_valid),
        .out_side  (r_side),
        .out_x     (c1),
        .out_y     (s1),
        .out_z     ()
    );

    gcd_cordic_chain u_rot_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vect      (1'b0),
        .in_valid  (m2_valid_reg),
        .in_side   (m2_side_reg),
        .in_x      ('0),
        .in_y      ('0),
        .in_z      (m2_side_reg.distr),
        .out_valid (),
        .out_side  (),
        .out_x     (cc),
        .out_y     (sc),
        .out_z     ()
    );

    gcd_cordic_chain u_rot_az (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vect      (1'b0),
        .in_valid  (m2_valid_reg),
        .in_side   (m2_side_reg),
        .in_x      ('0),
        .in_y      ('0),
        .in_z      (m2_side_reg.azr),
        .out_valid (),
        .out_side  (),
        .out_x     (ca),
        .out_y     (sa),
        .out_z     ()
    );

    // ---------------- spherical products ----------------
    logic                 p1_valid_reg;
    side_t                p1_side_reg;
    logic signed [XW-1:0] p1_c1_reg, p1_s1_reg, p1_scca_reg, p1_xl_reg;
    logic signed [XW-1:0] p1_s1cc_reg, p1_c1cc_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_side_reg <= r_side;
            p1_c1_reg   <= c1;
            p1_s1_reg   <= s1;
            p1_scca_reg <= mulq30(sc, ca);
            p1_xl_reg   <= mulq30(sc, sa);
            p1_s1cc_reg <= mulq30(s1, cc);
            p1_c1cc_reg <= mulq30(c1, cc);
        end
    end

    logic                 p2_valid_reg;
    side_t                p2_side_reg;
    logic signed [XW-1:0] p2_xl_reg, p2_s1cc_reg, p2_c1cc_reg, p2_ma_reg, p2_mb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_side_reg <= p1_side_reg;
            p2_xl_reg   <= p1_xl_reg;
            p2_s1cc_reg <= p1_s1cc_reg;
            p2_c1cc_reg <= p1_c1cc_reg;
            p2_ma_reg   <= mulq30(p1_c1_reg, p1_scca_reg);
            p2_mb_reg   <= mulq30(p1_s1_reg, p1_scca_reg);
        end
    end

    logic                 p3_valid_reg;
    side_t                p3_side_reg, p3_side_next;
    logic signed [XW-1:0] p3_xl_reg, p3_yl_reg;

    always_comb begin
        p3_side_next    = p2_side_reg;
        p3_side_next.c2 = p2_s1cc_reg + p2_ma_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_side_reg <= p3_side_next;
            p3_xl_reg   <= p2_xl_reg;
            p3_yl_reg   <= p2_c1cc_reg - p2_mb_reg;
        end
    end

    // longitude offset and horizontal magnitude
    logic                 v1_valid;
    side_t                v1_side;
    logic signed [XW-1:0] v1_x;
    logic signed [ZW-1:0] v1_z;

    gcd_cordic_chain u_vec_dlon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vect      (1'b1),
        .in_valid  (p3_valid_reg),
        .in_side   (p3_side_reg),
        .in_x      (p3_yl_reg),
        .in_y      (p3_xl_reg),
        .in_z      ('0),
        .out_valid (v1_valid),
        .out_side  (v1_side),
        .out_x     (v1_x),
        .out_y     (),
        .out_z     (v1_z)
    );

    logic                 p4_valid_reg;
    side_t                p4_side_reg, p4_side_next;
    logic signed [XW-1:0] p4_mag_reg;

    always_comb begin
        p4_side_next      = v1_side;
        p4_side_next.dlon = v1_z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_side_reg <= p4_side_next;
            p4_mag_reg  <= mulq30(v1_x, GAIN_Q30);
        end
    end

    logic                 p5_valid_reg;
    side_t                p5_side_reg;
    logic signed [XW-1:0] p5_vx_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p5_side_reg <= p4_side_reg;
            p5_vx_reg   <= geo_reg ? mulq30(FAC_Q30, p4_mag_reg) : p4_mag_reg;
        end
    end

    // end latitude as atan2 of sine over horizontal magnitude
    logic                 v2_valid;
    side_t                v2_side;
    logic signed [ZW-1:0] v2_z;

    gcd_cordic_chain u_vec_lat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vect      (1'b1),
        .in_valid  (p5_valid_reg),
        .in_side   (p5_side_reg),
        .in_x      (p5_vx_reg),
        .in_y      (p5_side_reg.c2),
        .in_z      ('0),
        .out_valid (v2_valid),
        .out_side  (v2_side),
        .out_x     (),
        .out_y     (),
        .out_z     (v2_z)
    );

    // ---------------- radians to degrees ----------------
    logic                 q1_valid_reg;
    status_t              q1_status_reg;
    logic signed [FIELD_W-1:0] q1_lon_reg;
    logic                 q1_neg_reg [2];
    logic [RH+R2D_W-1:0]  q1_plo_reg [2];
    logic [RH+R2D_W-1:0]  q1_phi_reg [2];
    logic signed [ZW-1:0] q1_r  [2];
    logic [ZW-1:0]        q1_ur [2];

    always_comb begin
        q1_r[0] = v2_side.dlon;
        q1_r[1] = v2_z;
        for (int i = 0; i < 2; i++)
            q1_ur[i] = q1_r[i][ZW-1] ? ZW'(-q1_r[i]) : ZW'(q1_r[i]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_status_reg <= v2_side.status;
            q1_lon_reg    <= v2_side.lon;
            for (int i = 0; i < 2; i++) begin
                q1_neg_reg[i] <= q1_r[i][ZW-1];
                q1_plo_reg[i] <= (RH+R2D_W)'(q1_ur[i][RH-1:0]) *
                                 (RH+R2D_W)'(R2D_Q30[R2D_W-1:0]);
                q1_phi_reg[i] <= (RH+R2D_W)'(q1_ur[i][ZW-1:RH]) *
                                 (RH+R2D_W)'(R2D_Q30[R2D_W-1:0]);
            end
        end
    end

    logic                      q2_valid_reg;
    status_t                   q2_status_reg;
    logic signed [FIELD_W-1:0] q2_lon_reg;
    logic signed [FIELD_W-1:0] q2_deg_reg [2];
    logic [RSUM_W-1:0]         q2_sum [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            q2_sum[i] = (RSUM_W'(q1_phi_reg[i]) << RH) + RSUM_W'(q1_plo_reg[i])
                      + (RSUM_W'(1) << (SH_R - 1));
            q2_sum[i] = q2_sum[i] >> SH_R;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q2_status_reg <= q1_status_reg;
            q2_lon_reg    <= q1_lon_reg;
            for (int i = 0; i < 2; i++)
                q2_deg_reg[i] <= q1_neg_reg[i] ? -FIELD_W'(q2_sum[i]) : FIELD_W'(q2_sum[i]);
        end
    end

    // final fields, errors force zero coordinates
    logic                    q3_valid_reg;
    status_t                 q3_status_reg;
    logic [LON_W-1:0]        q3_lon_reg;
    logic [LAT_W-1:0]        q3_lat_reg;
    logic [FIELD_W-1:0]      q3_lon_sum;

    assign q3_lon_sum = FIELD_W'(q2_lon_reg + q2_deg_reg[0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            q3_status_reg <= q2_status_reg;
            if (q2_status_reg != ST_OK) begin
                q3_lon_reg <= '0;
                q3_lat_reg <= '0;
            end else begin
                q3_lon_reg <= q3_lon_sum[LON_W-1:0];
                q3_lat_reg <= q2_deg_reg[1][LAT_W-1:0];
            end
        end
    end

    // valid bits of the top-level stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            q1_valid_reg <= 1'b0;
            q2_valid_reg <= 1'b0;
            q3_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_tvalid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            m1_valid_reg <= g1_valid;
            m2_valid_reg <= g2_valid;
            p1_valid_reg <= r_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= v1_valid;
            p5_valid_reg <= p4_valid_reg;
            q1_valid_reg <= v2_valid;
            q2_valid_reg <= q1_valid_reg;
            q3_valid_reg <= q2_valid_reg;
        end
    end

    // ---------------- output register and skid ----------------
    logic             m_valid_reg;
    logic             skid_valid_reg;
    logic [2:0]       m_status_reg, skid_status_reg;
    logic [LON_W-1:0] m_lon_reg, skid_lon_reg;
    logic [LAT_W-1:0] m_lat_reg, skid_lat_reg;

    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= q3_valid_reg;
            end
        end else if (q3_valid_reg && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_status_reg <= skid_status_reg;
                m_lon_reg    <= skid_lon_reg;
                m_lat_reg    <= skid_lat_reg;
            end else begin
                m_status_reg <= q3_status_reg;
                m_lon_reg    <= q3_lon_reg;
                m_lat_reg    <= q3_lat_reg;
            end
        end else if (!skid_valid_reg) begin
            skid_status_reg <= q3_status_reg;
            skid_lon_reg    <= q3_lon_reg;
            skid_lat_reg    <= q3_lat_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {(56 - LON_W - LAT_W)'(0), m_lat_reg, m_lon_reg};

`ifndef NO_ASSERTIONS
    // a parked result always has one in front of it
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a result while output is empty");

    // the skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid filled without a stall");

    // error results carry zero coordinates
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("error result with nonzero coordinates");
`endif

endmodule

[dv/great_circle_destination_point_top_test.sv]
module great_circle_destination_point_top_test
    import gcd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE          = 64'sd1 << FRACTION_BITS;
    localparam int     STAGES       = CORDIC_STAGES;
    localparam int     LATENCY      = 5 * (STAGES + 2) + 14;
    localparam int     IDLE_LIMIT   = 4000;
    localparam int     HOLD_CYCLES  = 500;
    localparam int     RANDOM_ITEMS = 380;

    // fixed-point constants for the end point predictor
    localparam longint unsigned PI61  = 64'h6487ED5110B4611A;
    localparam longint unsigned IPI64 = 64'h517CC1B727220A94;
    localparam longint PI40   = longint'((PI61 + (64'd1 << 20)) >> 21);
    localparam longint HPI40  = longint'((PI61 + (64'd1 << 21)) >> 22);
    localparam longint D2R61  = longint'((PI61 + 64'd90) / 64'd180);
    localparam longint R2D30  = longint'((((IPI64 >> 8) * 64'd180) + (64'd1 << 25)) >> 26);
    localparam longint GAIN30 = 64'sh26DD3B6A;
    localparam longint FAC30  = longint'(((64'd9932773 << 30) + 64'd5000000) / 64'd10000000);

    typedef struct {
        logic signed [FIELD_W-1:0] lon;
        logic signed [FIELD_W-1:0] lat;
        logic signed [FIELD_W-1:0] arc;
        logic signed [FIELD_W-1:0] az;
    } point_req_t;

    typedef struct {
        logic [LON_W-1:0] lon_end;
        logic [LAT_W-1:0] lat_end;
        status_t          status;
    } end_point_t;

    typedef struct {
        point_req_t req;
        bit         typed;
        end_point_t res;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_wdata = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [111:0]       s_tdata = '0;     // lon_start, lat_start, distance, azimuth
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [55:0]        m_tdata;          // lon_end, lat_end
    logic [2:0]         m_tuser;          // status

    great_circle_destination_point_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    longint     atan_q40 [64];
    bit         geo_mode;
    end_point_t pending_ends [$];
    int         mismatches;
    int         idle_cycles;
    int         gap_pct;
    int         stall_pct;
    int         hold_seq;
    int         hold_seen;
    int         hold_left;

    // rounded product, ties away from zero
    function automatic longint mul_round(longint a, longint b, int sh);
        logic                neg;
        longint unsigned     ua, ub, res;
        logic [127:0]        p;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? longint'(-a) : a;
        ub  = (b < 0) ? longint'(-b) : b;
        p   = {64'd0, ua} * {64'd0, ub};
        p   = p + (128'd1 << (sh - 1));
        res = 64'(p >> sh) & ((64'd1 << 62) - 1);
        return neg ? -longint'(res) : longint'(res);
    endfunction

    // rotation mode: cosine and sine of z
    function automatic void cordic_sincos(longint z, output longint c, output longint s);
        longint x, y, nx;
        bit     flip;
        x = GAIN30;
        y = 0;
        flip = 1'b0;
        if (z > HPI40) begin
            z = z - PI40;
            flip = 1'b1;
        end else if (z < -HPI40) begin
            z = z + PI40;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_q40[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_q40[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // vectoring mode: angle of (x, y) and its magnitude
    function automatic longint cordic_atan2(longint x, longint y, output longint mag);
        longint z, nx;
        z = 0;
        if (x == 0 && y == 0) begin
            mag = 0;
            return 0;
        end
        if (x < 0) begin
            z = (y >= 0) ? PI40 : -PI40;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_q40[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_q40[i];
            end
            x = nx;
        end
        mag = mul_round(x, GAIN30, 30);
        return z;
    endfunction

    function automatic longint to_rad(longint d);
        return mul_round(d, D2R61, 21 + FRACTION_BITS);
    endfunction

    function automatic longint to_deg(longint r);
        return mul_round(r, R2D30, 70 - FRACTION_BITS);
    endfunction

    // end point of one request under the current mode
    function automatic end_point_t predict_end_point(point_req_t r);
        end_point_t e;
        longint lon, lat, arc, az, lat1, c1, s1, cc, sc, ca, sa, scca;
        longint c2, xl, yl, dlon, mag, lat2, unused;
        lon  = r.lon;
        lat  = r.lat;
        arc  = r.arc;
        az   = r.az;
        e.lon_end = '0;
        e.lat_end = '0;
        e.status  = ST_OK;
        if (lon > 180 * ONE) lon = lon - 360 * ONE;
        if (az > 180 * ONE)  az = az - 360 * ONE;
        if (lat < -90 * ONE || lat > 90 * ONE)          e.status = ST_BAD_LAT;
        else if (lon < -180 * ONE || lon > 180 * ONE)   e.status = ST_BAD_LON;
        else if (arc < 0 || arc > 180 * ONE)            e.status = ST_BAD_DIST;
        else if (az < -180 * ONE || az > 180 * ONE)     e.status = ST_BAD_AZ;
        if (e.status != ST_OK) return e;

        if (geo_mode) begin
            if (lat == 90 * ONE) begin
                lat1 = HPI40;
            end else if (lat == -90 * ONE) begin
                lat1 = -HPI40;
            end else begin
                cordic_sincos(to_rad(lat), c1, s1);
                if (c1 < 0) c1 = 0;
                lat1 = cordic_atan2(c1, mul_round(FAC30, s1, 30), unused);
            end
        end else begin
            lat1 = to_rad(lat);
        end
        cordic_sincos(lat1, c1, s1);
        cordic_sincos(to_rad(arc), cc, sc);
        cordic_sincos(to_rad(az), ca, sa);

        scca = mul_round(sc, ca, 30);
        c2   = mul_round(s1, cc, 30) + mul_round(c1, scca, 30);
        xl   = mul_round(sc, sa, 30);
        yl   = mul_round(c1, cc, 30) - mul_round(s1, scca, 30);
        dlon = cordic_atan2(yl, xl, mag);
        if (geo_mode) lat2 = cordic_atan2(mul_round(FAC30, mag, 30), c2, unused);
        else          lat2 = cordic_atan2(mag, c2, unused);

        e.lon_end = LON_W'(lon + to_deg(dlon));
        e.lat_end = LAT_W'(to_deg(lat2));
        return e;
    endfunction

    // arctangent table from the series
    initial begin
        longint acc;
        atan_q40[0] = longint'((PI61 + (64'd1 << 22)) >> 23);
        for (int i = 1; i < 64; i++) begin
            acc = 0;
            for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
                if (k % 2) acc = acc - longint'((64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1));
                else       acc = acc + longint'((64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1));
            end
            atan_q40[i] = (acc + (64'sd1 <<< 21)) >>> 22;
        end
    end

    // receiver: random stalls and the long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result check and watchdog
    always @(posedge aclk) begin
        end_point_t want;
        end_point_t got;
        if (aresetn) begin
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles = 0;
            else idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got.lon_end = m_tdata[LON_W-1:0];
                got.lat_end = m_tdata[LON_W+LAT_W-1:LON_W];
                got.status  = status_t'(m_tuser);
                if (pending_ends.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: lon %h lat %h status %0d",
                                 got.lon_end, got.lat_end, got.status);
                end else begin
                    want = pending_ends.pop_front();
                    if (got.lon_end !== want.lon_end || got.lat_end !== want.lat_end ||
                        got.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp lon %h lat %h st %0d, got lon %h lat %h st %0d",
                                     want.lon_end, want.lat_end, want.status,
                                     got.lon_end, got.lat_end, got.status);
                    end
                end
            end
        end
    end

    // offer one transaction, with random gaps, and record its end point
    task automatic send_point(point_req_t r, bit typed, end_point_t typed_res);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, r.az, r.arc, r.lat, r.lon};
        do @(posedge aclk); while (!s_tready);
        pending_ends.push_back(typed ? typed_res : predict_end_point(r));
    endtask

    // register write while the pipeline is empty
    task automatic set_geo_mode(bit v);
        s_tvalid <= 1'b0;
        while (pending_ends.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        geo_mode   = v;
    endtask

    function automatic point_req_t rand_point();
        point_req_t r;
        if ($urandom_range(0, 99) < 25) begin
            r.lon  = FIELD_W'($urandom);
            r.lat  = FIELD_W'($urandom);
            r.arc  = FIELD_W'($urandom);
            r.az   = FIELD_W'($urandom);
        end else begin
            r.lon  = FIELD_W'(int'($urandom_range(0, 720 * ONE)) - 180 * ONE);
            r.lat  = FIELD_W'(int'($urandom_range(0, 180 * ONE)) - 90 * ONE);
            r.arc  = FIELD_W'($urandom_range(0, 180 * ONE));
            r.az   = FIELD_W'(int'($urandom_range(0, 720 * ONE)) - 180 * ONE);
            if ($urandom_range(0, 9) == 0)
                r.lat = FIELD_W'(($urandom_range(0, 1) ? 90 : -90) * ONE);
            if ($urandom_range(0, 9) == 0)
                r.arc = FIELD_W'(($urandom_range(0, 1) ? 180 : 0) * ONE);
        end
        return r;
    endfunction

    stim_row_t directed [$];

    function automatic stim_row_t row(int lon, int lat, int arc, int az, bit typed = 0,
                                      status_t st = ST_OK);
        stim_row_t s;
        s.req.lon  = FIELD_W'(lon);
        s.req.lat  = FIELD_W'(lat);
        s.req.arc  = FIELD_W'(arc);
        s.req.az   = FIELD_W'(az);
        s.typed    = typed;
        s.res.lon_end = '0;
        s.res.lat_end = '0;
        s.res.status  = st;
        return s;
    endfunction

    initial begin
        int gap_tab   [4] = '{0, 50, 0, 18};
        int stall_tab [4] = '{0, 0, 50, 18};
        bit mode_tab  [4] = '{0, 1, 0, 1};
        end_point_t none;
        int one;
        one = int'(ONE);
        none = '{default: '0, status: ST_OK};
        mismatches = 0;
        idle_cycles = 0;
        geo_mode = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_seq = 0;

        // out-of-range fields, in order of precedence
        directed.push_back(row(0, 90 * one + 1, 0, 0, 1, ST_BAD_LAT));
        directed.push_back(row(0, -67108864, 0, 0, 1, ST_BAD_LAT));
        directed.push_back(row(0, 67108863, -1, 600 * one, 1, ST_BAD_LAT));
        directed.push_back(row(-180 * one - 1, 0, 0, 0, 1, ST_BAD_LON));
        directed.push_back(row(67108863, 0, 0, 0, 1, ST_BAD_LON));
        directed.push_back(row(540 * one + 1, 0, -1, 0, 1, ST_BAD_LON));
        directed.push_back(row(0, 0, -1, 0, 1, ST_BAD_DIST));
        directed.push_back(row(0, 0, 180 * one + 1, 0, 1, ST_BAD_DIST));
        directed.push_back(row(0, 0, -67108864, 0, 1, ST_BAD_DIST));
        directed.push_back(row(0, 0, 0, -67108864, 1, ST_BAD_AZ));
        directed.push_back(row(0, 0, 0, 540 * one + 1, 1, ST_BAD_AZ));
        directed.push_back(row(0, 0, 0, -180 * one - 1, 1, ST_BAD_AZ));
        // edges of the valid ranges, poles, coincident and antipodal points
        directed.push_back(row(0, 0, 0, 0));
        directed.push_back(row(180 * one, 90 * one, 0, 0));
        directed.push_back(row(-180 * one, -90 * one, 180 * one, 180 * one));
        directed.push_back(row(540 * one, 0, 180 * one, 540 * one));
        directed.push_back(row(10 * one, 90 * one, 30 * one, 45 * one));
        directed.push_back(row(10 * one, -90 * one, 30 * one, -45 * one));
        directed.push_back(row(5 * one, 90 * one - 1, 1, 90 * one));
        directed.push_back(row(-5 * one, -90 * one + 1, 45 * one, -90 * one));
        directed.push_back(row(20 * one, 60 * one, 170 * one, 0));
        directed.push_back(row(-30 * one, 45 * one, 90 * one, -180 * one));
        directed.push_back(row(181 * one, 12345, 1234567, 270 * one));
        directed.push_back(row(-1, -1, 11796479, 35389439));

        // reset
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < 4; ph++) begin
            set_geo_mode(mode_tab[ph]);
            gap_pct   <= gap_tab[ph];
            stall_pct <= stall_tab[ph];
            if (ph == 0) hold_seq <= hold_seq + 1;
            if (ph < 2) begin
                foreach (directed[i])
                    send_point(directed[i].req, directed[i].typed, directed[i].res);
            end
            for (int n = 0; n < RANDOM_ITEMS; n++)
                send_point(rand_point(), 0, none);
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending_ends.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
